[rtl/ps2fr_pkg.sv]
// Shared types and constants for the PS/2 frame receiver with byte ring.
package ps2fr_pkg;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic [15:0] GAP_LIMIT_RESET = 16'd250;

  localparam logic [3:0] FIRST_DATA_BIT = 4'd2;
  localparam logic [3:0] LAST_DATA_BIT  = 4'd9;
  localparam logic [3:0] LAST_BIT       = 4'd11;

  localparam int RING_DEPTH_DEFAULT = 16;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
  } fr_push_t;

  typedef struct packed {
    logic dropped;
    logic popped;
    logic nonempty;
  } ring_stat_t;

endpackage

[rtl/ps2fr_if.sv]
// Valid/ready channel interfaces for receiver events and results.
interface ps2fr_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        data_bit;
  logic [15:0] gap_us;

  modport source (output valid, output kind, output data_bit, output gap_us, input ready);
  modport sink (input valid, input kind, input data_bit, input gap_us, output ready);
endinterface

interface ps2fr_res_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       ring_nonempty;
  logic       byte_dropped;

  modport source (output valid, output byte_valid, output rx_byte, output ring_nonempty,
                  output byte_dropped, input ready);
  modport sink (input valid, input byte_valid, input rx_byte, input ring_nonempty,
                input byte_dropped, output ready);
endinterface

[rtl/ps2fr_frame.sv]
// Frame bit counter and shift byte with gap resync.
module ps2fr_frame (
  input  logic               clk,
  input  logic               rst,
  input  logic               edge_en,
  input  logic               flush,
  input  logic               data_bit,
  input  logic [15:0]        gap_us,
  input  logic [15:0]        gap_limit,
  output ps2fr_pkg::fr_push_t push
);
  import ps2fr_pkg::*;

  logic [3:0] bit_count;
  logic [3:0] bit_count_next;
  logic [7:0] shift_byte;
  logic [7:0] shift_byte_next;
  logic [3:0] base_count;
  logic [7:0] base_shift;
  logic [3:0] inc_count;

  always_comb begin
    base_count = (gap_us > gap_limit) ? 4'd0 : bit_count;
    base_shift = (gap_us > gap_limit) ? 8'd0 : shift_byte;
    inc_count  = base_count + 4'd1;
    bit_count_next  = inc_count;
    shift_byte_next = base_shift;
    push.push = 1'b0;
    push.data = base_shift;
    if (inc_count >= FIRST_DATA_BIT && inc_count <= LAST_DATA_BIT) begin
      shift_byte_next = {data_bit, base_shift[7:1]};
    end else if (inc_count == LAST_BIT) begin
      push.push       = edge_en;
      bit_count_next  = 4'd0;
      shift_byte_next = 8'd0;
    end else if (inc_count > LAST_BIT) begin
      bit_count_next  = 4'd0;
      shift_byte_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      bit_count  <= 4'd0;
      shift_byte <= 8'd0;
    end else if (edge_en) begin
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
    end
  end

endmodule

[rtl/ps2fr_ring.sv]
// Byte ring with one spare slot, registered read port.
module ps2fr_ring #(
  parameter int RING_DEPTH = ps2fr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ps2fr_pkg::fr_push_t   push,
  input  logic                  pop,
  input  logic                  flush,
  output ps2fr_pkg::ring_stat_t stat,
  output logic [7:0]            rd_data
);
  import ps2fr_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  logic [7:0]    mem [RING_DEPTH];
  logic [AW-1:0] write_index;
  logic [AW-1:0] read_index;
  logic [AW-1:0] write_index_next;
  logic [AW-1:0] read_index_next;
  logic [AW-1:0] write_inc;
  logic [AW-1:0] read_inc;
  logic          full;
  logic          push_ok;

  always_comb begin
    write_inc = (write_index == LAST_SLOT) ? '0 : write_index + 1'b1;
    read_inc  = (read_index == LAST_SLOT) ? '0 : read_index + 1'b1;
    full      = (write_inc == read_index);
    push_ok   = push.push && !full;
    stat.dropped = push.push && full;
    stat.popped  = pop && (write_index != read_index);
    write_index_next = write_index;
    read_index_next  = read_index;
    if (flush) begin
      write_index_next = '0;
      read_index_next  = '0;
    end else begin
      if (push_ok) begin
        write_index_next = write_inc;
      end
      if (stat.popped) begin
        read_index_next = read_inc;
      end
    end
    stat.nonempty = (write_index_next != read_index_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok && !flush) begin
      mem[write_index] <= push.data;
    end
    if (stat.popped) begin
      rd_data <= mem[read_index];
    end
  end

endmodule

[rtl/ps2fr_result.sv]
// Result register that parts the event side from the result side.
module ps2fr_result (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ps2fr_pkg::ring_stat_t stat,
  input  logic [7:0]            rd_data,
  output logic                  hold_busy,
  ps2fr_res_if.source           out_ch
);
  import ps2fr_pkg::*;

  logic res_valid;
  logic byte_valid;
  logic nonempty;
  logic dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_valid <= stat.popped;
      nonempty   <= stat.nonempty;
      dropped    <= stat.dropped;
    end
  end

  assign hold_busy            = res_valid && !out_ch.ready;
  assign out_ch.valid         = res_valid;
  assign out_ch.byte_valid    = byte_valid;
  assign out_ch.rx_byte       = byte_valid ? rd_data : 8'd0;
  assign out_ch.ring_nonempty = nonempty;
  assign out_ch.byte_dropped  = dropped;

endmodule

[rtl/ps2_frame_receiver_fifo_unit.sv]
// Top level of the PS/2 frame receiver with byte ring.
//
//   port       dir  payload                                         beat
//   in_ch      in   kind, data_bit, gap_us                          valid & ready
//   out_ch     out  byte_valid, rx_byte, ring_nonempty, byte_dropped valid & ready
//   cfg_wr_*   in   gap_limit_us                                    cfg_wr_en
//
// One event per cycle while no result waits on a low out_ch.ready; its result appears in the cycle after acceptance.
// The ring read port and the result register load in the same cycle.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Reset empties the ring and frame and loads the gap limit with 250;
// ring contents are not cleared.
module ps2_frame_receiver_fifo_unit #(
  parameter int RING_DEPTH = ps2fr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  ps2fr_evt_if.sink   in_ch,
  ps2fr_res_if.source out_ch
);
  import ps2fr_pkg::*;

  logic [15:0] gap_limit_us;
  logic       accept;
  logic       is_edge;
  logic       is_pop;
  logic       is_flush;
  logic       hold_busy;
  fr_push_t   push;
  ring_stat_t stat;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit_us <= GAP_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      gap_limit_us <= cfg_wr_data;
    end
  end

  assign in_ch.ready = !hold_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    is_edge  = 1'b0;
    is_pop   = 1'b0;
    is_flush = 1'b0;
    case (in_ch.kind)
      KIND_EDGE:  is_edge  = accept;
      KIND_POP:   is_pop   = accept;
      KIND_FLUSH: is_flush = accept;
      default:    is_edge  = 1'b0;
    endcase
  end

  ps2fr_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .edge_en   (is_edge),
    .flush     (is_flush),
    .data_bit  (in_ch.data_bit),
    .gap_us    (in_ch.gap_us),
    .gap_limit (gap_limit_us),
    .push      (push)
  );

  ps2fr_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pop     (is_pop),
    .flush   (is_flush),
    .stat    (stat),
    .rd_data (rd_data)
  );

  ps2fr_result u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .stat      (stat),
    .rd_data   (rd_data),
    .hold_busy (hold_busy),
    .out_ch    (out_ch)
  );

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.kind == KIND_FLUSH |=> out_ch.valid && !out_ch.ring_nonempty)
    else $error("flush did not leave the ring empty");

  a_pop_not_drop: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.byte_valid |-> !out_ch.byte_dropped && out_ch.rx_byte == rd_data)
    else $error("popped beat also flags a drop or carries a stale byte");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("event side stalled without a waiting result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted event produced no result beat");

endmodule
